// ===== hw/rtl/adacc_pkg.sv =====
// ----------------------------------------------------------------------------
// adacc_pkg
// Shared constants, types, trigonometric tables and codes for the attractor
// density accumulator.
// ----------------------------------------------------------------------------
package adacc_pkg;

  localparam int GRID_W       = 256;
  localparam int GRID_H       = 128;
  localparam int WARMUP_STEPS = 50;
  localparam int TRIG_DEPTH   = 1024;

  localparam int TRIG_BITS = $clog2(TRIG_DEPTH);
  localparam int QUARTER   = TRIG_DEPTH / 4;
  localparam int QTR_BITS  = TRIG_BITS - 2;

  localparam int CELL_STORE = 32768;
  localparam int ADDR_W     = $clog2(CELL_STORE);
  localparam int NCELL      = (GRID_W * GRID_H < CELL_STORE) ? GRID_W * GRID_H : CELL_STORE;
  localparam int PX_W       = $clog2(GRID_W);
  localparam int PY_W       = $clog2(GRID_H);

  localparam int CNT_W       = 20;
  localparam int MAX_POINTS  = 600000;
  localparam int DENS_W      = 32;
  localparam int FADE_NUM    = 61604;
  localparam int HIT_Q8      = 256;
  localparam int START_Q12   = 410;
  localparam int INV_TWO_PI  = 683565276;
  localparam int PIX_BIAS    = 106496;
  localparam int PIX_DEN     = 212992;
  localparam longint unsigned PIX_RECIP = (64'd1 << 48) / PIX_DEN;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint ONE_Q30 = 64'sd1073741824;

  localparam int CFG_W = 3;
  localparam logic [CFG_W-1:0] CFG_MAP_KIND = 3'd0;
  localparam logic [CFG_W-1:0] CFG_COEF_A   = 3'd1;
  localparam logic [CFG_W-1:0] CFG_COEF_B   = 3'd2;
  localparam logic [CFG_W-1:0] CFG_COEF_C   = 3'd3;
  localparam logic [CFG_W-1:0] CFG_COEF_D   = 3'd4;
  localparam logic [CFG_W-1:0] CFG_POINTS   = 3'd5;

  localparam logic [1:0] FUNC_RUN   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_FADE, S_FADE_END, S_WARM, S_WARM_WAIT,
    S_RUN, S_RUN_WAIT, S_HIT_RD, S_HIT_WR, S_READ, S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic cnt_clear;
    logic cnt_inc;
    logic clr_wr;
    logic fade_en;
    logic pt_init;
    logic step_start;
    logic hit_rd;
    logic hit_wr;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_store_end;
    logic cnt_cell_end;
    logic warm_end;
    logic run_end;
    logic step_done;
    logic hit_ok;
    logic out_full;
  } ctrl_status_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               hit;
    logic [ADDR_W-1:0]  addr;
  } step_res_t;

  typedef logic signed [15:0] qtab_t [QUARTER];

  function automatic longint unsigned tstep(longint unsigned term, longint unsigned x2);
    return (term * x2) >> 30;
  endfunction

  function automatic logic signed [15:0] round_q14(longint s);
    longint c;
    c = (s < 0) ? 64'sd0 : s;
    if (c > ONE_Q30) c = ONE_Q30;
    return 16'((c + 64'sd32768) >>> 16);
  endfunction

  function automatic logic signed [15:0] sin_q14(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint s;
    x2 = (x * x) >> 30;
    t = x;
    s = longint'(x);
    t = tstep(t, x2) / 6;   s = s - longint'(t);
    t = tstep(t, x2) / 20;  s = s + longint'(t);
    t = tstep(t, x2) / 42;  s = s - longint'(t);
    t = tstep(t, x2) / 72;  s = s + longint'(t);
    t = tstep(t, x2) / 110; s = s - longint'(t);
    t = tstep(t, x2) / 156; s = s + longint'(t);
    t = tstep(t, x2) / 210; s = s - longint'(t);
    return round_q14(s);
  endfunction

  function automatic logic signed [15:0] cos_q14(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint s;
    x2 = (x * x) >> 30;
    t = longint'(ONE_Q30);
    s = ONE_Q30;
    t = tstep(t, x2) / 2;   s = s - longint'(t);
    t = tstep(t, x2) / 12;  s = s + longint'(t);
    t = tstep(t, x2) / 30;  s = s - longint'(t);
    t = tstep(t, x2) / 56;  s = s + longint'(t);
    t = tstep(t, x2) / 90;  s = s - longint'(t);
    t = tstep(t, x2) / 132; s = s + longint'(t);
    t = tstep(t, x2) / 182; s = s - longint'(t);
    return round_q14(s);
  endfunction

  function automatic qtab_t build_qtab(bit want_cos);
    qtab_t tab;
    longint unsigned x;
    for (int j = 0; j < QUARTER; j++) begin
      x = (PI_HALF_Q30 * longint'(j)) / QUARTER;
      tab[j] = want_cos ? cos_q14(x) : sin_q14(x);
    end
    return tab;
  endfunction

  localparam qtab_t QSIN = build_qtab(1'b0);
  localparam qtab_t QCOS = build_qtab(1'b1);

  function automatic logic signed [15:0] sine_lookup(logic [TRIG_BITS-1:0] idx);
    logic [QTR_BITS-1:0] r;
    r = idx[QTR_BITS-1:0];
    case (idx[TRIG_BITS-1 -: 2])
      2'd0:    return QSIN[r];
      2'd1:    return QCOS[r];
      2'd2:    return -QSIN[r];
      default: return -QCOS[r];
    endcase
  endfunction

endpackage

// ===== hw/rtl/adacc_map.sv =====
// ----------------------------------------------------------------------------
// adacc_map
// Nine-stage pipeline for one map step: phase products, sine table lookup,
// new point, and pixel position with its grid address.
// ----------------------------------------------------------------------------
module adacc_map (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                map_kind,
  input  logic signed [15:0]  coef_a,
  input  logic signed [15:0]  coef_b,
  input  logic signed [15:0]  coef_c,
  input  logic signed [15:0]  coef_d,
  input  logic signed [15:0]  pt_x,
  input  logic signed [15:0]  pt_y,
  output adacc_pkg::step_res_t res
);
  import adacc_pkg::*;

  localparam int NSTAGE = 9;
  localparam int Q_W    = 13;
  localparam logic signed [30:0] INV_S = 31'(INV_TWO_PI);

  logic [NSTAGE-1:0]       vld_r;
  logic signed [31:0]      p_r [4];
  logic [TRIG_BITS-1:0]    idx_r [4];
  logic signed [15:0]      t_r [4];
  logic signed [15:0]      u_r [4];
  logic signed [31:0]      q1_r, q3_r;
  logic signed [15:0]      nx_r, ny_r;
  logic signed [31:0]      ux_r, uy_r;
  logic signed [31:0]      ux2_r, uy2_r;
  logic [Q_W-1:0]          qx_r, qy_r;
  logic                    negx_r, negy_r, smallx_r, smally_r;
  logic [PX_W-1:0]         px_r;
  logic [PY_W-1:0]         py_r;
  logic                    pxok_r, pyok_r;
  logic                    hit_r;
  logic [ADDR_W-1:0]       addr_r;

  logic signed [15:0]      cb1, cb2, cb3;
  logic signed [62:0]      ph_prod [4];
  logic signed [16:0]      dj_x, dj_y;
  logic signed [31:0]      cf_x, cf_y;
  logic signed [15:0]      nx_nxt, ny_nxt;
  logic signed [31:0]      vx, vy;
  logic [61:0]             rx, ry;
  logic [31:0]             remx, remy;
  logic [Q_W:0]            qxc, qyc;
  logic [31:0]             idx_full;

  function automatic logic signed [15:0] sat16(logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7FFF;
    if (v < -32'sd32768) return 16'sh8000;
    return 16'(v);
  endfunction

  always_comb begin
    cb1 = map_kind ? coef_a : coef_b;
    cb2 = map_kind ? coef_b : coef_c;
    cb3 = map_kind ? coef_b : coef_d;
    for (int k = 0; k < 4; k++) begin
      ph_prod[k] = p_r[k] * INV_S;
    end
    dj_x = 17'(u_r[0]) - 17'(u_r[1]);
    dj_y = 17'(u_r[2]) - 17'(u_r[3]);
    cf_x = (32'(u_r[0]) <<< 12) + q1_r;
    cf_y = (32'(u_r[2]) <<< 12) + q3_r;
    if (map_kind) begin
      nx_nxt = sat16(cf_x >>> 14);
      ny_nxt = sat16(cf_y >>> 14);
    end else begin
      nx_nxt = 16'(dj_x >>> 2);
      ny_nxt = 16'(dj_y >>> 2);
    end
    vx = 32'(PIX_BIAS) + 32'sd10 * 32'(nx_r);
    vy = 32'(PIX_BIAS) + 32'sd10 * 32'(ny_r);
    rx = 62'(ux_r[30:0]) * 62'(PIX_RECIP);
    ry = 62'(uy_r[30:0]) * 62'(PIX_RECIP);
    remx = 32'(ux2_r) - 32'(qx_r) * 32'(PIX_DEN);
    remy = 32'(uy2_r) - 32'(qy_r) * 32'(PIX_DEN);
    qxc = (remx >= 32'(PIX_DEN)) ? (Q_W+1)'(qx_r) + 1'b1 : (Q_W+1)'(qx_r);
    qyc = (remy >= 32'(PIX_DEN)) ? (Q_W+1)'(qy_r) + 1'b1 : (Q_W+1)'(qy_r);
    idx_full = 32'(py_r) * 32'(GRID_W) + 32'(px_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTAGE-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    p_r[0] <= coef_a * pt_y;
    p_r[1] <= cb1 * pt_x;
    p_r[2] <= cb2 * pt_x;
    p_r[3] <= cb3 * pt_y;
    idx_r[0] <= ph_prod[0][55 -: TRIG_BITS];
    idx_r[1] <= ph_prod[1][55 -: TRIG_BITS] + TRIG_BITS'(QUARTER);
    idx_r[2] <= ph_prod[2][55 -: TRIG_BITS];
    idx_r[3] <= ph_prod[3][55 -: TRIG_BITS] + TRIG_BITS'(QUARTER);
    for (int k = 0; k < 4; k++) begin
      t_r[k] <= sine_lookup(idx_r[k]);
      u_r[k] <= t_r[k];
    end
    q1_r <= coef_c * t_r[1];
    q3_r <= coef_d * t_r[3];
    nx_r <= nx_nxt;
    ny_r <= ny_nxt;
    ux_r <= 32'(GRID_W) * vx;
    uy_r <= 32'(GRID_H) * vy;
    ux2_r    <= ux_r;
    uy2_r    <= uy_r;
    qx_r     <= rx[48 +: Q_W];
    qy_r     <= ry[48 +: Q_W];
    negx_r   <= ux_r < 0;
    negy_r   <= uy_r < 0;
    smallx_r <= (-ux_r) < 32'(PIX_DEN);
    smally_r <= (-uy_r) < 32'(PIX_DEN);
    px_r   <= negx_r ? '0 : PX_W'(qxc);
    py_r   <= negy_r ? '0 : PY_W'(qyc);
    pxok_r <= negx_r ? smallx_r : (32'(qxc) < 32'(GRID_W));
    pyok_r <= negy_r ? smally_r : (32'(qyc) < 32'(GRID_H));
    hit_r  <= pxok_r && pyok_r && (idx_full < 32'(NCELL));
    addr_r <= ADDR_W'(idx_full);
  end

  assign res.done = vld_r[NSTAGE-1];
  assign res.nx   = nx_r;
  assign res.ny   = ny_r;
  assign res.hit  = hit_r;
  assign res.addr = addr_r;

endmodule

// ===== hw/rtl/adacc_datapath.sv =====
// ----------------------------------------------------------------------------
// adacc_datapath
// Configuration registers, density memory, point, counters, fade and hit
// arithmetic, and the result register.
// ----------------------------------------------------------------------------
module adacc_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  adacc_pkg::ctrl_cmd_t            cmd,
  output adacc_pkg::ctrl_status_t         status,
  input  logic                            cfg_we,
  input  logic [adacc_pkg::CFG_W-1:0]     cfg_index,
  input  logic [19:0]                     cfg_data,
  input  logic [1:0]                      in_func,
  input  logic [14:0]                     in_cell_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_density_value,
  output logic [19:0]                     out_points_plotted
);
  import adacc_pkg::*;

  logic                     map_kind_r;
  logic signed [15:0]       coef_a_r, coef_b_r, coef_c_r, coef_d_r;
  logic [CNT_W-1:0]         ppf_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [1:0]               func_r;
  logic [14:0]              cell_r;
  logic signed [15:0]       pt_x_r, pt_y_r;
  logic [CNT_W-1:0]         hits_r;
  logic [DENS_W-1:0]        mem [CELL_STORE];
  logic [DENS_W-1:0]        rd_r;
  logic                     fade_wr_r;
  logic [ADDR_W-1:0]        fade_addr_r;
  logic                     out_valid_r;
  logic [31:0]              density_r;
  logic [19:0]              plotted_r;

  step_res_t                sres;
  logic [CNT_W-1:0]         steps;
  logic [47:0]              fprod;
  logic [DENS_W-1:0]        hit_sum;
  logic                     we;
  logic [ADDR_W-1:0]        wa, ra;
  logic [DENS_W-1:0]        wd;

  adacc_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.step_start),
    .map_kind (map_kind_r),
    .coef_a   (coef_a_r),
    .coef_b   (coef_b_r),
    .coef_c   (coef_c_r),
    .coef_d   (coef_d_r),
    .pt_x     (pt_x_r),
    .pt_y     (pt_y_r),
    .res      (sres)
  );

  always_comb begin
    steps   = (ppf_r < CNT_W'(MAX_POINTS)) ? ppf_r : CNT_W'(MAX_POINTS);
    fprod   = rd_r * 16'(FADE_NUM);
    hit_sum = (rd_r > (32'hFFFF_FFFF - 32'(HIT_Q8))) ? 32'hFFFF_FFFF : rd_r + 32'(HIT_Q8);
    we = cmd.clr_wr | fade_wr_r | cmd.hit_wr;
    wa = sres.addr;
    wd = hit_sum;
    if (cmd.clr_wr) begin
      wa = cnt_r[ADDR_W-1:0];
      wd = '0;
    end else if (fade_wr_r) begin
      wa = fade_addr_r;
      wd = fprod[47:16];
    end
    ra = cell_r;
    if (cmd.fade_en) begin
      ra = cnt_r[ADDR_W-1:0];
    end else if (cmd.hit_rd) begin
      ra = sres.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_kind_r  <= 1'b0;
      coef_a_r    <= '0;
      coef_b_r    <= '0;
      coef_c_r    <= '0;
      coef_d_r    <= '0;
      ppf_r       <= CNT_W'(65536);
      cnt_r       <= '0;
      pt_x_r      <= 16'(START_Q12);
      pt_y_r      <= 16'(START_Q12);
      hits_r      <= '0;
      fade_wr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAP_KIND: map_kind_r <= cfg_data[0];
          CFG_COEF_A:   coef_a_r   <= cfg_data[15:0];
          CFG_COEF_B:   coef_b_r   <= cfg_data[15:0];
          CFG_COEF_C:   coef_c_r   <= cfg_data[15:0];
          CFG_COEF_D:   coef_d_r   <= cfg_data[15:0];
          CFG_POINTS:   ppf_r      <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.cnt_clear) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.pt_init) begin
        pt_x_r <= 16'(START_Q12);
        pt_y_r <= 16'(START_Q12);
        hits_r <= '0;
      end else begin
        if (sres.done) begin
          pt_x_r <= sres.nx;
          pt_y_r <= sres.ny;
        end
        if (cmd.hit_wr) begin
          hits_r <= hits_r + 1'b1;
        end
      end
      fade_wr_r <= cmd.fade_en;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fade_addr_r <= cnt_r[ADDR_W-1:0];
    if (cmd.load_in) begin
      func_r <= in_func;
      cell_r <= in_cell_index;
    end
    if (cmd.res_load) begin
      density_r <= (func_r == FUNC_READ && 32'(cell_r) < 32'(NCELL)) ? rd_r : '0;
      plotted_r <= (func_r == FUNC_RUN) ? hits_r : '0;
    end
  end

  assign status.cnt_store_end = (cnt_r == CNT_W'(CELL_STORE - 1));
  assign status.cnt_cell_end  = (cnt_r == CNT_W'(NCELL - 1));
  assign status.warm_end      = (cnt_r == CNT_W'(WARMUP_STEPS));
  assign status.run_end       = (cnt_r == steps);
  assign status.step_done     = sres.done;
  assign status.hit_ok        = sres.hit;
  assign status.out_full      = out_valid_r & ~out_ready;

  assign out_valid          = out_valid_r;
  assign out_density_value  = density_r;
  assign out_points_plotted = plotted_r;

endmodule

// ===== hw/rtl/adacc_ctrl.sv =====
// ----------------------------------------------------------------------------
// adacc_ctrl
// Sequencer for clearing, fading, warm-up and plotted map steps, cell reads
// and the hand-over of each result.
// ----------------------------------------------------------------------------
module adacc_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [1:0]               in_func,
  output logic                     in_ready,
  input  adacc_pkg::ctrl_status_t  status,
  output adacc_pkg::ctrl_cmd_t     cmd
);
  import adacc_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:      if (status.cnt_store_end) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FUNC_RUN:   state_nxt = S_FADE;
            FUNC_CLEAR: state_nxt = S_CLEAR;
            FUNC_READ:  state_nxt = S_READ;
            default:    state_nxt = S_RESP;
          endcase
        end
      end
      S_CLEAR:     if (status.cnt_store_end) state_nxt = S_RESP;
      S_FADE:      if (status.cnt_cell_end) state_nxt = S_FADE_END;
      S_FADE_END:  state_nxt = S_WARM;
      S_WARM:      state_nxt = status.warm_end ? S_RUN : S_WARM_WAIT;
      S_WARM_WAIT: if (status.step_done) state_nxt = S_WARM;
      S_RUN:       state_nxt = status.run_end ? S_RESP : S_RUN_WAIT;
      S_RUN_WAIT: begin
        if (status.step_done) state_nxt = status.hit_ok ? S_HIT_RD : S_RUN;
      end
      S_HIT_RD:    state_nxt = S_HIT_WR;
      S_HIT_WR:    state_nxt = S_RUN;
      S_READ:      state_nxt = S_RESP;
      S_RESP:      if (!status.out_full) state_nxt = S_IDLE;
      default:     state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_INIT, S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_store_end) cmd.cnt_clear = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in   = 1'b1;
          cmd.cnt_clear = 1'b1;
        end
      end
      S_FADE: begin
        cmd.fade_en = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_FADE_END: begin
        cmd.cnt_clear = 1'b1;
        cmd.pt_init   = 1'b1;
      end
      S_WARM: begin
        if (status.warm_end) cmd.cnt_clear = 1'b1;
        else cmd.step_start = 1'b1;
      end
      S_WARM_WAIT, S_RUN_WAIT: begin
        if (status.step_done) cmd.cnt_inc = 1'b1;
      end
      S_RUN: begin
        if (!status.run_end) cmd.step_start = 1'b1;
      end
      S_HIT_RD: cmd.hit_rd = 1'b1;
      S_HIT_WR: cmd.hit_wr = 1'b1;
      S_RESP: begin
        if (!status.out_full) cmd.res_load = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/attractor_density_accumulator.sv =====
// ----------------------------------------------------------------------------
// attractor_density_accumulator
// Keeps a density grid fed by a de Jong or Clifford attractor and answers
// run-frame, clear and read requests, one result word per request word.
// ----------------------------------------------------------------------------
// Usage: request words arrive on in_valid/in_ready with in_func and
// in_cell_index; one result word leaves on out_valid/out_ready. Map kind,
// coefficients and points per frame are written on cfg_valid/cfg_ready
// (always ready); cfg_index selects the register. The user must write
// them only while the block is idle; the block does not enforce this.
// One request is worked on at a time. A read passes through the READ and
// RESP states before its result is registered; a clear writes all 32768
// memory entries, one memory entry per cycle. A run frame fades NCELL cells
// (one cell per cycle through the memory port), then runs the 50 warm-up
// and the plotted steps, each through the nine-stage step pipeline whose
// new point feeds the next step, with a read-modify-write of the cell in
// the HIT_RD and HIT_WR states for each hit. After reset the memory is
// cleared in a pass over all 32768 entries, during which no request is
// taken. A result waits in the output register while the receiver stalls;
// a request may be taken meanwhile, but its result waits for that word.
// ----------------------------------------------------------------------------
module attractor_density_accumulator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [14:0]                   in_cell_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_density_value,
  output logic [19:0]                   out_points_plotted,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [adacc_pkg::CFG_W-1:0]   cfg_index,
  input  logic [19:0]                   cfg_data
);
  import adacc_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  adacc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  adacc_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_func            (in_func),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_density_value  (out_density_value),
    .out_points_plotted (out_points_plotted)
  );

endmodule

// ===== hw/rtl/adacc_checker.sv =====
// ----------------------------------------------------------------------------
// adacc_checker
// Port-level checks for the attractor density accumulator, bound to the top.
// ----------------------------------------------------------------------------
module adacc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_density_value,
  input logic [19:0] out_points_plotted
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Request word taken while the previous one is in progress.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_density_value)
      && $stable(out_points_plotted))
    else $error("Stalled result word changed or dropped.");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_density_value == 32'd0) || (out_points_plotted == 20'd0))
    else $error("Result word carries both a density and a hit count.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("Block not quiet after reset.");

endmodule

bind attractor_density_accumulator adacc_checker u_adacc_checker (.*);
